@@ hw/rtl/kary_huffman_code_builder_unit_defines.svh @@
// Assertion macros for the code builder RTL.
`ifndef KARY_HUFFMAN_CODE_BUILDER_UNIT_DEFINES_SVH
`define KARY_HUFFMAN_CODE_BUILDER_UNIT_DEFINES_SVH
`ifndef SYNTHESIS
`define KHCB_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);
`define KHCB_ASSERT_RST(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);
`else
`define KHCB_ASSERT(lbl, prop, msg)
`define KHCB_ASSERT_RST(lbl, prop, msg)
`endif
`endif

@@ hw/rtl/khcb_pkg.sv @@
// Shared types, codes and defaults of the k-ary Huffman code builder.
package khcb_pkg;

    localparam int KHCB_SYMBOLS      = 256;
    localparam int KHCB_MAX_RADIX    = 10;
    localparam int KHCB_MAX_CODE_LEN = 32;
    localparam int KHCB_COUNT_BITS   = 32;

    localparam int DIGIT_W = 4;

    localparam logic [1:0] OP_COUNT  = 2'd0;
    localparam logic [1:0] OP_BUILD  = 2'd1;
    localparam logic [1:0] OP_ENCODE = 2'd2;
    localparam logic [1:0] OP_UNUSED = 2'd3;

    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_ABSENT = 2'd1;
    localparam logic [1:0] ST_LONG   = 2'd2;
    localparam logic [1:0] ST_SAT    = 2'd3;

    typedef struct packed {
        logic [1:0] op;
        logic [7:0] symbol;
    } t_in_item;

    typedef struct packed {
        logic [3:0] digit;
        logic [5:0] code_length;
        logic       last;
        logic [1:0] status;
    } t_out_item;

    typedef enum logic [4:0] {
        CMD_NONE, CMD_LATCH, CMD_CNT_RD, CMD_CNT_WR, CMD_B_INIT, CMD_H_RD, CMD_H_WR,
        CMD_EMPTY, CMD_SETUP, CMD_MOD_STEP, CMD_GRP_FIRST, CMD_GRP_FULL, CMD_SCAN,
        CMD_TAKE, CMD_NEWNODE, CMD_P_INIT, CMD_S_RD, CMD_SKIP, CMD_W1_INIT, CMD_W1_RD,
        CMD_W1_STEP, CMD_FIN_SYM, CMD_W2_RD, CMD_W2_WR, CMD_ADV, CMD_B_DONE,
        CMD_NOT_BUILT, CMD_E_SRD, CMD_E_CHK, CMD_E_RD, CMD_E_LD
    } t_dp_cmd;

    typedef struct packed {
        logic empty;
        logic sym_last;
        logic mod_done;
        logic first_multi;
        logic more_groups;
        logic scan_done;
        logic grp_last;
        logic present;
        logic has_parent;
        logic too_long;
        logic depth_zero;
        logic j_one;
        logic built;
        logic e_stream;
        logic out_last;
    } t_dp_stat;

    typedef logic [7:0] t_sym_tab [256];

    // Fold a byte into the symbol range by repeated subtraction.
    function automatic t_sym_tab sym_mod_table(input int n);
        t_sym_tab tab;
        int       v;
        for (int i = 0; i < 256; i++) begin
            v = i;
            while (v >= n) begin
                v = v - n;
            end
            tab[i] = 8'(v);
        end
        return tab;
    endfunction

endpackage

@@ hw/rtl/khcb_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module khcb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end
endmodule

@@ hw/rtl/khcb_ctrl.sv @@
// Controller state machine: sequences count, build and encode requests.
`include "kary_huffman_code_builder_unit_defines.svh"
module khcb_ctrl import khcb_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    input  logic [1:0] i_op,
    output logic     o_in_ready,
    output logic     o_out_valid,
    input  logic     i_out_ready,
    input  t_dp_stat i_stat,
    output t_dp_cmd  o_cmd
);
    typedef enum logic [4:0] {
        S_IDLE, S_CNT_RD, S_CNT_WR, S_B_INIT, S_H_RD, S_H_WR, S_B_CHK, S_MOD, S_LOOP,
        S_SCAN, S_TAKE, S_NEW, S_P_INIT, S_S_RD, S_S_CHK, S_W1_RD, S_W1_CHK, S_FIN,
        S_W2_RD, S_W2_WR, S_ADV, S_B_DONE, S_E_START, S_E_CHK, S_E_RD, S_E_LD, S_OUT
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   last_take;
    logic   nop_take;

    always_comb begin
        n_state = r_state;
        o_cmd   = CMD_NONE;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd = CMD_LATCH;
                    case (i_op)
                        OP_COUNT:  n_state = S_CNT_RD;
                        OP_BUILD:  n_state = S_B_INIT;
                        OP_ENCODE: n_state = S_E_START;
                        default:   n_state = S_IDLE;
                    endcase
                end
            end
            S_CNT_RD: begin o_cmd = CMD_CNT_RD; n_state = S_CNT_WR; end
            S_CNT_WR: begin o_cmd = CMD_CNT_WR; n_state = S_OUT; end
            S_B_INIT: begin o_cmd = CMD_B_INIT; n_state = S_H_RD; end
            S_H_RD:   begin o_cmd = CMD_H_RD; n_state = S_H_WR; end
            S_H_WR: begin
                o_cmd   = CMD_H_WR;
                n_state = i_stat.sym_last ? S_B_CHK : S_H_RD;
            end
            S_B_CHK: begin
                if (i_stat.empty) begin
                    o_cmd = CMD_EMPTY; n_state = S_OUT;
                end else begin
                    o_cmd = CMD_SETUP; n_state = S_MOD;
                end
            end
            S_MOD: begin
                if (!i_stat.mod_done) begin
                    o_cmd = CMD_MOD_STEP;
                end else if (i_stat.first_multi) begin
                    o_cmd = CMD_GRP_FIRST; n_state = S_SCAN;
                end else begin
                    n_state = S_LOOP;
                end
            end
            S_LOOP: begin
                if (i_stat.more_groups) begin
                    o_cmd = CMD_GRP_FULL; n_state = S_SCAN;
                end else begin
                    n_state = S_P_INIT;
                end
            end
            S_SCAN: begin
                o_cmd = CMD_SCAN;
                if (i_stat.scan_done) begin
                    n_state = S_TAKE;
                end
            end
            S_TAKE: begin
                o_cmd   = CMD_TAKE;
                n_state = i_stat.grp_last ? S_NEW : S_SCAN;
            end
            S_NEW:    begin o_cmd = CMD_NEWNODE; n_state = S_LOOP; end
            S_P_INIT: begin o_cmd = CMD_P_INIT; n_state = S_S_RD; end
            S_S_RD:   begin o_cmd = CMD_S_RD; n_state = S_S_CHK; end
            S_S_CHK: begin
                if (i_stat.present) begin
                    o_cmd = CMD_W1_INIT; n_state = S_W1_RD;
                end else begin
                    o_cmd   = CMD_SKIP;
                    n_state = i_stat.sym_last ? S_B_DONE : S_S_RD;
                end
            end
            S_W1_RD: begin o_cmd = CMD_W1_RD; n_state = S_W1_CHK; end
            S_W1_CHK: begin
                if (i_stat.has_parent) begin
                    o_cmd = CMD_W1_STEP; n_state = S_W1_RD;
                end else begin
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                o_cmd   = CMD_FIN_SYM;
                n_state = (i_stat.too_long || i_stat.depth_zero) ? S_ADV : S_W2_RD;
            end
            S_W2_RD: begin o_cmd = CMD_W2_RD; n_state = S_W2_WR; end
            S_W2_WR: begin
                o_cmd   = CMD_W2_WR;
                n_state = i_stat.j_one ? S_ADV : S_W2_RD;
            end
            S_ADV: begin
                o_cmd   = CMD_ADV;
                n_state = i_stat.sym_last ? S_B_DONE : S_S_RD;
            end
            S_B_DONE: begin o_cmd = CMD_B_DONE; n_state = S_OUT; end
            S_E_START: begin
                if (i_stat.built) begin
                    o_cmd = CMD_E_SRD; n_state = S_E_CHK;
                end else begin
                    o_cmd = CMD_NOT_BUILT; n_state = S_OUT;
                end
            end
            S_E_CHK: begin
                o_cmd   = CMD_E_CHK;
                n_state = i_stat.e_stream ? S_E_RD : S_OUT;
            end
            S_E_RD: begin o_cmd = CMD_E_RD; n_state = S_E_LD; end
            S_E_LD: begin o_cmd = CMD_E_LD; n_state = S_OUT; end
            S_OUT: begin
                if (i_out_ready) begin
                    n_state = i_stat.out_last ? S_IDLE : S_E_RD;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = (r_state == S_OUT);
    assign last_take   = o_out_valid && i_out_ready && i_stat.out_last;
    assign nop_take    = i_in_valid && o_in_ready && (i_op == OP_UNUSED);

    `KHCB_ASSERT_RST(a_rst_idle, (!i_rst_n) |=> o_in_ready, "reset must leave the block idle")
    `KHCB_ASSERT(a_excl, !(o_in_ready && o_out_valid), "request taken while a result waits")
    `KHCB_ASSERT(a_last_idle, last_take |=> o_in_ready, "last result must free the block")
    `KHCB_ASSERT(a_nop_idle, nop_take |=> o_in_ready, "unused op must be dropped")
endmodule

@@ hw/rtl/khcb_dp.sv @@
// Datapath: histogram, tree and code memories with their counters.
module khcb_dp import khcb_pkg::*; #(
    parameter int SYMBOLS      = KHCB_SYMBOLS,
    parameter int MAX_RADIX    = KHCB_MAX_RADIX,
    parameter int MAX_CODE_LEN = KHCB_MAX_CODE_LEN,
    parameter int COUNT_BITS   = KHCB_COUNT_BITS
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_dp_cmd   i_cmd,
    output t_dp_stat  o_stat,
    input  t_in_item  i_in_data,
    input  logic      i_cfg_valid,
    input  logic [3:0] i_cfg_data,
    output t_out_item o_out_data
);
    localparam int NODES      = 2 * SYMBOLS - 1;
    localparam int NI_W       = $clog2(NODES);
    localparam int NC_W       = $clog2(NODES + 1);
    localparam int SYM_W      = $clog2(SYMBOLS);
    localparam int W_W        = COUNT_BITS + $clog2(SYMBOLS);
    localparam int LEN_W      = $clog2(MAX_CODE_LEN + 1);
    localparam int K_W        = $clog2(MAX_RADIX + 1);
    localparam int CODE_DEPTH = SYMBOLS * MAX_CODE_LEN;
    localparam int CA_W       = $clog2(CODE_DEPTH);
    localparam int NODE_BITS  = 2 + NI_W + DIGIT_W + W_W;
    localparam int SW_BITS    = 2 + LEN_W;
    localparam int SLOT_LO    = W_W;
    localparam int PAR_LO     = W_W + DIGIT_W;
    localparam int HP_BIT     = PAR_LO + NI_W;
    localparam int LIVE_BIT   = HP_BIT + 1;
    localparam t_sym_tab SymTab = sym_mod_table(SYMBOLS);

    // Control state.
    logic [3:0]        r_radix;
    logic              r_built;
    logic              r_hvalid [SYMBOLS];

    // Working registers.
    logic [SYM_W-1:0]  r_sym;
    logic [SYM_W-1:0]  r_s;
    logic [K_W-1:0]    r_k;
    logic [NC_W-1:0]   r_n;
    logic [NC_W-1:0]   r_total;
    logic [NC_W-1:0]   r_live;
    logic [NC_W-1:0]   r_rem;
    logic [NC_W-1:0]   r_idx;
    logic [NI_W-1:0]   r_pidx;
    logic              r_pv;
    logic [NI_W-1:0]   r_best;
    logic [W_W-1:0]    r_best_w;
    logic              r_best_ok;
    logic [W_W-1:0]    r_wsum;
    logic [K_W-1:0]    r_gsize;
    logic [K_W-1:0]    r_gcnt;
    logic [NI_W-1:0]   r_leaf;
    logic [NI_W-1:0]   r_x;
    logic [NC_W-1:0]   r_d;
    logic [LEN_W-1:0]  r_j;
    logic [LEN_W-1:0]  r_len;
    logic              r_bad;
    t_out_item         r_out;

    // Memory ports.
    logic                  h_re, h_we;
    logic [SYM_W-1:0]      h_raddr, h_waddr;
    logic [COUNT_BITS-1:0] h_wdata, h_rdata, h_val;
    logic                  nm_re, nm_we;
    logic [NI_W-1:0]       nm_raddr, nm_waddr;
    logic [NODE_BITS-1:0]  nm_wdata, nm_rdata;
    logic                  s_re, s_we;
    logic [SYM_W-1:0]      s_raddr, s_waddr;
    logic [SW_BITS-1:0]    s_wdata, s_rdata;
    logic                  c_re, c_we;
    logic [CA_W-1:0]       c_raddr, c_waddr;
    logic [DIGIT_W-1:0]    c_rdata;

    logic [K_W-1:0]        k_clamp;
    logic [K_W-1:0]        km1;
    logic [SYM_W-1:0]      h_idx;
    logic                  h_sat;
    logic                  s_present, s_long;
    logic [LEN_W-1:0]      s_len;
    logic [W_W-1:0]        nd_w;
    logic                  cand;

    assign km1       = r_k - 1'b1;
    assign h_idx     = (i_cmd == CMD_CNT_WR) ? r_sym : r_s;
    assign h_val     = r_hvalid[h_idx] ? h_rdata : '0;
    assign h_sat     = &h_val;
    assign s_present = s_rdata[SW_BITS-1];
    assign s_long    = s_rdata[SW_BITS-2];
    assign s_len     = s_rdata[LEN_W-1:0];
    assign nd_w      = nm_rdata[W_W-1:0];
    assign cand      = r_pv && nm_rdata[LIVE_BIT] && (!r_best_ok || nd_w < r_best_w);

    always_comb begin
        if (r_radix < 4'd2) begin
            k_clamp = K_W'(2);
        end else if (int'(r_radix) > MAX_RADIX) begin
            k_clamp = K_W'(MAX_RADIX);
        end else begin
            k_clamp = K_W'(r_radix);
        end
    end

    always_comb begin
        h_re = 1'b0; h_raddr = r_s;  h_we = 1'b0; h_waddr = r_sym; h_wdata = h_val + 1'b1;
        nm_re = 1'b0; nm_raddr = r_x; nm_we = 1'b0; nm_waddr = r_best; nm_wdata = '0;
        s_re = 1'b0; s_raddr = r_s;  s_we = 1'b0; s_waddr = r_s;   s_wdata = '0;
        c_re = 1'b0; c_we = 1'b0;
        c_raddr = CA_W'(r_sym) * CA_W'(MAX_CODE_LEN) + CA_W'(r_j);
        c_waddr = CA_W'(r_s) * CA_W'(MAX_CODE_LEN) + CA_W'(r_j - 1'b1);
        case (i_cmd)
            CMD_CNT_RD: begin h_re = 1'b1; h_raddr = r_sym; end
            CMD_CNT_WR: h_we = !h_sat;
            CMD_H_RD:   h_re = 1'b1;
            CMD_H_WR: begin
                s_we     = 1'b1;
                s_wdata  = {(h_val != '0), 1'b0, LEN_W'(0)};
                nm_we    = (h_val != '0);
                nm_waddr = NI_W'(r_n);
                nm_wdata = {1'b1, 1'b0, NI_W'(0), DIGIT_W'(0), W_W'(h_val)};
            end
            CMD_SCAN: begin
                nm_re    = (r_idx < r_total);
                nm_raddr = NI_W'(r_idx);
            end
            CMD_TAKE: begin
                nm_we    = 1'b1;
                nm_wdata = {1'b0, 1'b1, NI_W'(r_total), DIGIT_W'(r_gcnt), r_best_w};
            end
            CMD_NEWNODE: begin
                nm_we    = 1'b1;
                nm_waddr = NI_W'(r_total);
                nm_wdata = {1'b1, 1'b0, NI_W'(0), DIGIT_W'(0), r_wsum};
            end
            CMD_S_RD:  s_re = 1'b1;
            CMD_W1_RD: nm_re = 1'b1;
            CMD_W2_RD: nm_re = 1'b1;
            CMD_FIN_SYM: begin
                s_we = 1'b1;
                if (r_d > NC_W'(MAX_CODE_LEN)) begin
                    s_wdata = {1'b1, 1'b1, LEN_W'(0)};
                end else begin
                    s_wdata = {1'b1, 1'b0, LEN_W'(r_d)};
                end
            end
            CMD_W2_WR:  c_we = 1'b1;
            CMD_E_SRD:  begin s_re = 1'b1; s_raddr = r_sym; end
            CMD_E_RD:   c_re = 1'b1;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_radix <= 4'd2;
            r_built <= 1'b0;
            for (int i = 0; i < SYMBOLS; i++) begin
                r_hvalid[i] <= 1'b0;
            end
        end else begin
            if (i_cfg_valid) begin
                r_radix <= i_cfg_data;
            end
            if (i_cmd == CMD_B_INIT) begin
                r_built <= 1'b1;
            end
            if (i_cmd == CMD_CNT_WR && !h_sat) begin
                r_hvalid[r_sym] <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        case (i_cmd)
            CMD_LATCH: r_sym <= SYM_W'(SymTab[i_in_data.symbol]);
            CMD_CNT_WR: r_out <= {4'd0, 6'd0, 1'b1, (h_sat ? ST_SAT : ST_OK)};
            CMD_B_INIT: begin
                r_k   <= k_clamp;
                r_s   <= '0;
                r_n   <= '0;
                r_bad <= 1'b0;
            end
            CMD_H_WR: begin
                r_s <= r_s + 1'b1;
                if (h_val != '0) begin
                    r_n <= r_n + 1'b1;
                end
            end
            CMD_EMPTY: r_out <= {4'd0, 6'd0, 1'b1, ST_ABSENT};
            CMD_SETUP: begin
                r_total <= r_n;
                r_live  <= r_n;
                r_rem   <= r_n - 1'b1;
            end
            CMD_MOD_STEP: r_rem <= r_rem - NC_W'(km1);
            CMD_GRP_FIRST, CMD_GRP_FULL: begin
                r_gsize   <= (i_cmd == CMD_GRP_FIRST) ? K_W'(r_rem + 1'b1) : r_k;
                r_gcnt    <= '0;
                r_wsum    <= '0;
                r_idx     <= '0;
                r_pv      <= 1'b0;
                r_best_ok <= 1'b0;
            end
            CMD_SCAN: begin
                r_pv   <= (r_idx < r_total);
                r_pidx <= NI_W'(r_idx);
                if (r_idx < r_total) begin
                    r_idx <= r_idx + 1'b1;
                end
                if (cand) begin
                    r_best    <= r_pidx;
                    r_best_w  <= nd_w;
                    r_best_ok <= 1'b1;
                end
            end
            CMD_TAKE: begin
                r_wsum    <= r_wsum + r_best_w;
                r_gcnt    <= r_gcnt + 1'b1;
                r_idx     <= '0;
                r_pv      <= 1'b0;
                r_best_ok <= 1'b0;
            end
            CMD_NEWNODE: begin
                r_total <= r_total + 1'b1;
                r_live  <= r_live - NC_W'(r_gsize) + 1'b1;
            end
            CMD_P_INIT: begin
                r_s    <= '0;
                r_leaf <= '0;
            end
            CMD_SKIP: r_s <= r_s + 1'b1;
            CMD_W1_INIT: begin
                r_x <= r_leaf;
                r_d <= '0;
            end
            CMD_W1_STEP: begin
                r_x <= nm_rdata[PAR_LO +: NI_W];
                r_d <= r_d + 1'b1;
            end
            CMD_FIN_SYM: begin
                r_x <= r_leaf;
                r_j <= LEN_W'(r_d);
                if (r_d > NC_W'(MAX_CODE_LEN)) begin
                    r_bad <= 1'b1;
                end
            end
            CMD_W2_WR: begin
                r_j <= r_j - 1'b1;
                r_x <= nm_rdata[PAR_LO +: NI_W];
            end
            CMD_ADV: begin
                r_s    <= r_s + 1'b1;
                r_leaf <= r_leaf + 1'b1;
            end
            CMD_B_DONE: r_out <= {4'd0, 6'd0, 1'b1, (r_bad ? ST_LONG : ST_OK)};
            CMD_NOT_BUILT: r_out <= {4'd0, 6'd0, 1'b1, ST_SAT};
            CMD_E_CHK: begin
                r_j   <= '0;
                r_len <= s_len;
                if (!s_present) begin
                    r_out <= {4'd0, 6'd0, 1'b1, ST_ABSENT};
                end else if (s_long) begin
                    r_out <= {4'd0, 6'd0, 1'b1, ST_LONG};
                end else begin
                    r_out <= {4'd0, 6'd0, 1'b1, ST_OK};
                end
            end
            CMD_E_LD: begin
                r_out <= {c_rdata, 6'(r_len), (r_j + 1'b1 == r_len), ST_OK};
                r_j   <= r_j + 1'b1;
            end
            default: ;
        endcase
    end

    always_comb begin
        o_stat.empty       = (r_n == '0);
        o_stat.sym_last    = (r_s == SYM_W'(SYMBOLS - 1));
        o_stat.mod_done    = (r_rem < NC_W'(km1));
        o_stat.first_multi = (r_rem != '0);
        o_stat.more_groups = (r_live > NC_W'(1)) && (r_live >= NC_W'(r_k));
        o_stat.scan_done   = (r_idx == r_total) && !r_pv;
        o_stat.grp_last    = (r_gcnt + 1'b1 == r_gsize);
        o_stat.present     = s_present;
        o_stat.has_parent  = nm_rdata[HP_BIT];
        o_stat.too_long    = (r_d > NC_W'(MAX_CODE_LEN));
        o_stat.depth_zero  = (r_d == '0);
        o_stat.j_one       = (r_j == LEN_W'(1));
        o_stat.built       = r_built;
        o_stat.e_stream    = s_present && !s_long && (s_len != '0);
        o_stat.out_last    = r_out.last;
    end

    assign o_out_data = r_out;

    khcb_ram #(.WIDTH(COUNT_BITS), .DEPTH(SYMBOLS)) u_hist (
        .i_clk(i_clk), .i_we(h_we), .i_waddr(h_waddr), .i_wdata(h_wdata),
        .i_re(h_re), .i_raddr(h_raddr), .o_rdata(h_rdata)
    );

    khcb_ram #(.WIDTH(NODE_BITS), .DEPTH(NODES)) u_node (
        .i_clk(i_clk), .i_we(nm_we), .i_waddr(nm_waddr), .i_wdata(nm_wdata),
        .i_re(nm_re), .i_raddr(nm_raddr), .o_rdata(nm_rdata)
    );

    khcb_ram #(.WIDTH(SW_BITS), .DEPTH(SYMBOLS)) u_sym (
        .i_clk(i_clk), .i_we(s_we), .i_waddr(s_waddr), .i_wdata(s_wdata),
        .i_re(s_re), .i_raddr(s_raddr), .o_rdata(s_rdata)
    );

    khcb_ram #(.WIDTH(DIGIT_W), .DEPTH(CODE_DEPTH)) u_code (
        .i_clk(i_clk), .i_we(c_we), .i_waddr(c_waddr),
        .i_wdata(nm_rdata[SLOT_LO +: DIGIT_W]),
        .i_re(c_re), .i_raddr(c_raddr), .o_rdata(c_rdata)
    );
endmodule

@@ hw/rtl/kary_huffman_code_builder_unit.sv @@
// Count request: histogram read, then write back, before the result is offered.
// Encode request: the code length is checked, then each digit is read from the code RAM in turn.
// Build request: one pass over the histogram, then per merged node one scan of all nodes per
// child through the single node RAM port, then a two-pass walk up the tree per leaf.
// One request at a time; the block is ready only when the last result has been taken.
// Reset (i_rst_n low, synchronous) clears histogram valid bits, table-built flag, radix = 2.
module kary_huffman_code_builder_unit import khcb_pkg::*; #(
    parameter int SYMBOLS      = KHCB_SYMBOLS,
    parameter int MAX_RADIX    = KHCB_MAX_RADIX,
    parameter int MAX_CODE_LEN = KHCB_MAX_CODE_LEN,
    parameter int COUNT_BITS   = KHCB_COUNT_BITS
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_in_item  i_in_data,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_item o_out_data,
    input  logic      i_cfg_valid,
    output logic      o_cfg_ready,
    input  logic [3:0] i_cfg_data
);
    t_dp_cmd  cmd;
    t_dp_stat stat;

    // Radix writes land at once; the user must send them only while idle, the block does not enforce this.
    assign o_cfg_ready = 1'b1;

    // Controller: hold the sequence of each request and drive the handshakes.
    khcb_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_op       (i_in_data.op),
        .o_in_ready (o_in_ready),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    // Datapath: memories, tree build counters and the result register.
    khcb_dp #(
        .SYMBOLS     (SYMBOLS),
        .MAX_RADIX   (MAX_RADIX),
        .MAX_CODE_LEN(MAX_CODE_LEN),
        .COUNT_BITS  (COUNT_BITS)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (cmd),
        .o_stat     (stat),
        .i_in_data  (i_in_data),
        .i_cfg_valid(i_cfg_valid),
        .i_cfg_data (i_cfg_data),
        .o_out_data (o_out_data)
    );
endmodule
